// ----- sv/bmp24_stream_to_framebuffer_pixels_top_defines.svh -----
// Assertion macros for the BMP byte-stream decoder checker.
// Each macro expects i_clk in the scope where it is used; all but BMP24_ASSERT_RST also expect i_rst_n.
`ifndef BMP24_STREAM_TO_FRAMEBUFFER_PIXELS_TOP_DEFINES_SVH
`define BMP24_STREAM_TO_FRAMEBUFFER_PIXELS_TOP_DEFINES_SVH

// Same-cycle implication, masked during reset.
`define BMP24_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked during reset.
`define BMP24_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also looks at the reset cycles themselves.
`define BMP24_ASSERT_RST(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/bmp24_pkg.sv -----
// ----------------------------------------------------------------------------
// bmp24_pkg
// Shared types and constants for the BMP 24-bit byte-stream decoder.
// ----------------------------------------------------------------------------
package bmp24_pkg;

    // Result kinds
    localparam logic [2:0] KIND_PIXEL    = 3'd0;
    localparam logic [2:0] KIND_HDR_OK   = 3'd1;
    localparam logic [2:0] KIND_BAD_SIG  = 3'd2;
    localparam logic [2:0] KIND_BAD_BPP  = 3'd3;
    localparam logic [2:0] KIND_BAD_SIZE = 3'd4;

    // Output pixel formats
    localparam logic [1:0] FMT_RGB565 = 2'd0;

    // Depth of the queue between parser and formatter
    localparam int QUEUE_DEPTH = 2;

    // One parsed event, handed from the parser to the formatter
    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] row_cnt;     // rows already completed, bottom-up
        logic [11:0] height12;    // image height, low bits
        logic [11:0] col;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] width13;
        logic [12:0] height13;
        logic        last;
    } t_job;

    // One result item as shown on the output channel
    typedef struct packed {
        logic [2:0]  kind;
        logic [11:0] row;
        logic [11:0] column;
        logic [23:0] pixel;
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic        last;
    } t_res;

endpackage

// ----- sv/bmp24_in_if.sv -----
// ----------------------------------------------------------------------------
// bmp24_in_if
// Byte channel into the decoder: valid/ready with one file byte per item.
// ----------------------------------------------------------------------------
interface bmp24_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       start_req;

    modport source (output valid, output byte_in, output start_req, input ready);
    modport sink   (input valid, input byte_in, input start_req, output ready);
endinterface

// ----- sv/bmp24_out_if.sv -----
// ----------------------------------------------------------------------------
// bmp24_out_if
// Result channel out of the decoder: valid/ready with one pixel or verdict.
// ----------------------------------------------------------------------------
interface bmp24_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [11:0] row;
    logic [11:0] column;
    logic [23:0] pixel;
    logic [12:0] image_width;
    logic [12:0] image_height;
    logic        last;

    modport source (output valid, output kind, output row, output column, output pixel,
                    output image_width, output image_height, output last, input ready);
    modport sink   (input valid, input kind, input row, input column, input pixel,
                    input image_width, input image_height, input last, output ready);
endinterface

// ----- sv/bmp24_queue.sv -----
// ----------------------------------------------------------------------------
// bmp24_queue
// Short FIFO of parsed events between the parser and the formatter.
// ----------------------------------------------------------------------------
module bmp24_queue
    import bmp24_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    t_job             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - CNT_W'(1);
            end
        end
    end

endmodule

// ----- sv/bmp24_front.sv -----
// ----------------------------------------------------------------------------
// bmp24_front
// Byte parser: header fields, verdict, skip to pixel data, triplet gathering,
// row padding. Pushes one event into the queue for each result.
// ----------------------------------------------------------------------------
module bmp24_front
    import bmp24_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    bmp24_in_if.sink     i_byte,
    input  logic         i_q_full,
    output logic         o_push,
    output t_job         o_job
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);

    // Parse phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;
    localparam logic [2:0] PH_ERROR  = 3'd5;

    // Header byte positions
    localparam logic [4:0] HB_SIG0 = 5'd0;
    localparam logic [4:0] HB_SIG1 = 5'd1;
    localparam logic [4:0] HB_OFF0 = 5'd10;
    localparam logic [4:0] HB_OFF1 = 5'd11;
    localparam logic [4:0] HB_OFF2 = 5'd12;
    localparam logic [4:0] HB_OFF3 = 5'd13;
    localparam logic [4:0] HB_WID0 = 5'd18;
    localparam logic [4:0] HB_WID1 = 5'd19;
    localparam logic [4:0] HB_WID2 = 5'd20;
    localparam logic [4:0] HB_WID3 = 5'd21;
    localparam logic [4:0] HB_HGT0 = 5'd22;
    localparam logic [4:0] HB_HGT1 = 5'd23;
    localparam logic [4:0] HB_HGT2 = 5'd24;
    localparam logic [4:0] HB_HGT3 = 5'd25;
    localparam logic [4:0] HB_BPP0 = 5'd28;
    localparam logic [4:0] HB_BPP1 = 5'd29;

    localparam logic [7:0]  SIG_B      = 8'h42;
    localparam logic [7:0]  SIG_M      = 8'h4D;
    localparam logic [15:0] BPP_24     = 16'd24;
    localparam logic [31:0] MIN_OFFSET = 32'd54;
    localparam logic [31:0] DIM_LIMIT  = 32'(MAX_DIM);

    logic [31:0]      r_cnt,    c_cnt,    n_cnt;
    logic [2:0]       r_phase,  c_phase,  n_phase;
    logic [31:0]      r_width,  c_width,  n_width;
    logic [31:0]      r_height, c_height, n_height;
    logic [7:0]       r_bpp_lo, c_bpp_lo, n_bpp_lo;
    logic [31:0]      r_off,    c_off,    n_off;
    logic [1:0]       r_trip,   c_trip,   n_trip;
    logic [15:0]      r_hold,   c_hold,   n_hold;
    logic [DIM_W-1:0] r_col,    c_col,    n_col;
    logic [DIM_W-1:0] r_row,    c_row,    n_row;
    logic [1:0]       r_pad,    c_pad,    n_pad;

    logic             fire;
    logic             start;
    logic             pix_go;
    logic [15:0]      bpp;
    logic [DIM_W-1:0] col_nx;
    logic [DIM_W-1:0] row_nx;
    logic [7:0]       b;

    assign i_byte.ready = !i_q_full;
    assign fire         = i_byte.valid && !i_q_full;
    assign start        = i_byte.start_req;
    assign b            = i_byte.byte_in;

    always_comb begin
        // a start request sees the cleared parse state
        c_cnt    = start ? '0 : r_cnt;
        c_phase  = start ? PH_HEADER : r_phase;
        c_width  = start ? '0 : r_width;
        c_height = start ? '0 : r_height;
        c_bpp_lo = start ? '0 : r_bpp_lo;
        c_off    = start ? '0 : r_off;
        c_trip   = start ? '0 : r_trip;
        c_hold   = start ? '0 : r_hold;
        c_col    = start ? '0 : r_col;
        c_row    = start ? '0 : r_row;
        c_pad    = start ? '0 : r_pad;

        n_cnt    = (c_cnt == '1) ? c_cnt : c_cnt + 32'd1;
        n_phase  = c_phase;
        n_width  = c_width;
        n_height = c_height;
        n_bpp_lo = c_bpp_lo;
        n_off    = c_off;
        n_trip   = c_trip;
        n_hold   = c_hold;
        n_col    = c_col;
        n_row    = c_row;
        n_pad    = c_pad;

        o_push   = 1'b0;
        o_job    = '0;
        pix_go   = 1'b0;
        bpp      = {b, c_bpp_lo};
        col_nx   = c_col + DIM_W'(1);
        row_nx   = c_row + DIM_W'(1);

        unique case (c_phase)
            PH_HEADER: begin
                unique case (c_cnt[4:0])
                    HB_SIG0: n_hold[7:0] = b;
                    HB_SIG1: begin
                        if (c_hold[7:0] != SIG_B || b != SIG_M) begin
                            o_push     = 1'b1;
                            o_job.kind = KIND_BAD_SIG;
                            n_phase    = PH_ERROR;
                        end
                    end
                    HB_OFF0: n_off[7:0]      = b;
                    HB_OFF1: n_off[15:8]     = b;
                    HB_OFF2: n_off[23:16]    = b;
                    HB_OFF3: n_off[31:24]    = b;
                    HB_WID0: n_width[7:0]    = b;
                    HB_WID1: n_width[15:8]   = b;
                    HB_WID2: n_width[23:16]  = b;
                    HB_WID3: n_width[31:24]  = b;
                    HB_HGT0: n_height[7:0]   = b;
                    HB_HGT1: n_height[15:8]  = b;
                    HB_HGT2: n_height[23:16] = b;
                    HB_HGT3: n_height[31:24] = b;
                    HB_BPP0: n_bpp_lo        = b;
                    HB_BPP1: begin
                        o_push = 1'b1;
                        if (bpp != BPP_24) begin
                            o_job.kind = KIND_BAD_BPP;
                            n_phase    = PH_ERROR;
                        end else if (c_width > DIM_LIMIT || c_height > DIM_LIMIT
                                     || c_off < MIN_OFFSET) begin
                            o_job.kind = KIND_BAD_SIZE;
                            n_phase    = PH_ERROR;
                        end else begin
                            o_job.kind     = KIND_HDR_OK;
                            o_job.width13  = c_width[12:0];
                            o_job.height13 = c_height[12:0];
                            // an empty image has no pixel data to wait for
                            n_phase = (c_width == '0 || c_height == '0) ? PH_DONE : PH_SKIP;
                        end
                    end
                    default: ;
                endcase
            end
            PH_SKIP: begin
                if (c_cnt >= c_off) begin
                    n_phase = PH_PIXEL;
                    pix_go  = 1'b1;
                end
            end
            PH_PIXEL: pix_go = 1'b1;
            PH_PAD: begin
                n_pad = c_pad - 2'd1;
                if (n_pad == '0) begin
                    n_phase = PH_PIXEL;
                end
            end
            default: ;
        endcase

        if (pix_go) begin
            case (c_trip)
                2'd0: begin
                    n_hold[7:0] = b;
                    n_trip      = 2'd1;
                end
                2'd1: begin
                    n_hold[15:8] = b;
                    n_trip       = 2'd2;
                end
                default: begin
                    n_trip         = 2'd0;
                    o_push         = 1'b1;
                    o_job.kind     = KIND_PIXEL;
                    o_job.row_cnt  = 12'(c_row);
                    o_job.height12 = c_height[11:0];
                    o_job.col      = 12'(c_col);
                    o_job.red      = b;
                    o_job.green    = c_hold[15:8];
                    o_job.blue     = c_hold[7:0];
                    if (col_nx == c_width[DIM_W-1:0]) begin
                        // end of a stored row
                        n_col = '0;
                        n_row = row_nx;
                        if (row_nx == c_height[DIM_W-1:0]) begin
                            o_job.last = 1'b1;
                            n_phase    = PH_DONE;
                        end else begin
                            n_pad = c_width[1:0];
                            if (n_pad != '0) begin
                                n_phase = PH_PAD;
                            end
                        end
                    end else begin
                        n_col = col_nx;
                    end
                end
            endcase
        end

        // nothing moves without an accepted byte
        if (!fire) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_phase  <= PH_HEADER;
            r_width  <= '0;
            r_height <= '0;
            r_bpp_lo <= '0;
            r_off    <= '0;
            r_trip   <= '0;
            r_hold   <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pad    <= '0;
        end else if (fire) begin
            r_cnt    <= n_cnt;
            r_phase  <= n_phase;
            r_width  <= n_width;
            r_height <= n_height;
            r_bpp_lo <= n_bpp_lo;
            r_off    <= n_off;
            r_trip   <= n_trip;
            r_hold   <= n_hold;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pad    <= n_pad;
        end
    end

endmodule

// ----- sv/bmp24_back.sv -----
// ----------------------------------------------------------------------------
// bmp24_back
// Formatter: converts queued events to result items, flips the row order,
// clears fields that do not apply, and holds the output register.
// ----------------------------------------------------------------------------
module bmp24_back
    import bmp24_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    input  logic        i_q_empty,
    input  t_job        i_job,
    output logic        o_pop,
    bmp24_out_if.source o_pix
);

    logic [1:0] r_fmt;
    logic       r_valid;
    t_res       r_res;
    t_res       n_res;
    logic       load;

    assign load  = !i_q_empty && (!r_valid || o_pix.ready);
    assign o_pop = load;

    always_comb begin
        n_res      = '0;
        n_res.kind = i_job.kind;
        unique case (i_job.kind)
            KIND_PIXEL: begin
                // stored rows run bottom-up
                n_res.row    = i_job.height12 - 12'd1 - i_job.row_cnt;
                n_res.column = i_job.col;
                n_res.last   = i_job.last;
                if (r_fmt == FMT_RGB565) begin
                    n_res.pixel = {8'h00, i_job.red[7:3], i_job.green[7:2], i_job.blue[7:3]};
                end else begin
                    n_res.pixel = {i_job.red, i_job.green, i_job.blue};
                end
            end
            KIND_HDR_OK: begin
                n_res.image_width  = i_job.width13;
                n_res.image_height = i_job.height13;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt   <= FMT_RGB565;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_fmt <= i_cfg_wdata;
            end
            if (load) begin
                r_valid <= 1'b1;
            end else if (o_pix.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res <= n_res;
        end
    end

    assign o_pix.valid        = r_valid;
    assign o_pix.kind         = r_res.kind;
    assign o_pix.row          = r_res.row;
    assign o_pix.column       = r_res.column;
    assign o_pix.pixel        = r_res.pixel;
    assign o_pix.image_width  = r_res.image_width;
    assign o_pix.image_height = r_res.image_height;
    assign o_pix.last         = r_res.last;

endmodule

// ----- sv/bmp24_stream_to_framebuffer_pixels_top.sv -----
// ----------------------------------------------------------------------------
// bmp24_stream_to_framebuffer_pixels_top
// BMP 24-bit byte-stream decoder producing framebuffer pixels.
// ----------------------------------------------------------------------------
// Usage:
//   i_byte carries one file byte per item; start_req marks the first byte of a
//   new file and restarts the parse on that byte. o_pix carries one result per
//   item: a header verdict (bad signature on byte 1; accepted, bad depth or
//   size/offset error on byte 29), then one pixel for every third data byte,
//   with its row counted from the top, its column and a last flag on the
//   final pixel. Bytes that cause no result (header filler, skip, padding,
//   trailing data, anything after an error) are taken and dropped.
//   i_cfg_we/i_cfg_wdata set the pixel format: 0 RGB565, otherwise packed RGB;
//   write it only while the block is idle.
// Timing:
//   One byte per cycle sustained while the queue is not full. A result
//   reaches o_pix through the event queue register, then the output
//   register. The parser decides everything for a byte combinationally.
// Stalls and reset:
//   When o_pix is held off, results collect in a two-entry queue; i_byte.ready
//   drops only once the queue is full. Synchronous reset clears the parse to
//   the start of a header, empties the queue and the output register, and sets
//   the format to RGB565.
// ----------------------------------------------------------------------------
module bmp24_stream_to_framebuffer_pixels_top
    import bmp24_pkg::*;
#(
    parameter int MAX_DIM = 4096
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_wdata,
    bmp24_in_if.sink    i_byte,
    bmp24_out_if.source o_pix
);

    // parser to queue
    logic q_push;
    t_job q_in;
    logic q_full;

    // queue to formatter
    logic q_pop;
    logic q_empty;
    t_job q_out;

    // Parse bytes; stall only on a full queue
    bmp24_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (q_in)
    );

    // Decouple the parser from the output handshake
    bmp24_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_out)
    );

    // Convert and present results
    bmp24_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_empty   (q_empty),
        .i_job       (q_out),
        .o_pop       (q_pop),
        .o_pix       (o_pix)
    );

endmodule

// ----- sv/bmp24_chk.sv -----
// ----------------------------------------------------------------------------
// bmp24_chk
// Port-level checker for the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "bmp24_stream_to_framebuffer_pixels_top_defines.svh"

module bmp24_chk
    import bmp24_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [2:0]  i_kind,
    input logic [11:0] i_row,
    input logic [11:0] i_column,
    input logic [23:0] i_pixel,
    input logic [12:0] i_image_width,
    input logic [12:0] i_image_height,
    input logic        i_last
);

    `BMP24_ASSERT_NEXT(a_stall_hold, i_out_valid && !i_out_ready, i_out_valid && $stable(i_kind) && $stable(i_pixel) && $stable(i_row) && $stable(i_column), "result changed while stalled")

    `BMP24_ASSERT(a_pixel_no_dims, i_out_valid && i_kind == KIND_PIXEL, i_image_width == '0 && i_image_height == '0, "pixel result carries image size")

    `BMP24_ASSERT(a_verdict_clean, i_out_valid && i_kind != KIND_PIXEL, i_row == '0 && i_column == '0 && i_pixel == '0 && !i_last, "verdict carries pixel fields")

    // a full queue always has a result waiting in the output register
    `BMP24_ASSERT(a_backpressure, !i_in_ready, i_out_valid, "input stalled with no result waiting")

    `BMP24_ASSERT_RST(a_reset_empty, !i_rst_n, !i_out_valid, "result shown right after reset")

endmodule

bind bmp24_stream_to_framebuffer_pixels_top bmp24_chk u_bmp24_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_ready     (i_byte.ready),
    .i_out_valid    (o_pix.valid),
    .i_out_ready    (o_pix.ready),
    .i_kind         (o_pix.kind),
    .i_row          (o_pix.row),
    .i_column       (o_pix.column),
    .i_pixel        (o_pix.pixel),
    .i_image_width  (o_pix.image_width),
    .i_image_height (o_pix.image_height),
    .i_last         (o_pix.last)
);

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the BMP 24-bit byte-stream decoder. File bytes are
// queued per image and fed through the byte channel; every accepted byte also
// runs through an in-bench decoder that tracks header parsing, skipping,
// triplet assembly and row padding. Its predicted verdicts and pixels are
// compared field by field with what leaves the result channel, under every
// pixel format and several pacing patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bmp24_pkg::*;

    // Image and header geometry
    localparam int unsigned IMG_MAX    = 4096;
    localparam logic [7:0]  SIG_B      = 8'h42;
    localparam logic [7:0]  SIG_M      = 8'h4D;
    localparam logic [15:0] DEPTH_RGB  = 16'd24;
    localparam logic [31:0] MIN_OFFSET = 32'd54;
    localparam int          HDR_BYTES  = 30;
    localparam int          POS_OFFSET = 10;
    localparam int          POS_WIDTH  = 18;
    localparam int          POS_HEIGHT = 22;
    localparam int          POS_DEPTH  = 28;

    // Pixel formats beyond the one the package names
    localparam logic [1:0] FMT_PACKED24   = 2'd1;
    localparam logic [1:0] FMT_XRGB32     = 2'd2;
    localparam logic [1:0] FMT_XRGB32_ALT = 2'd3;

    // Run control
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_BYTES   = 85;
    localparam int SETTLE_CYCLES = 8;
    localparam int DRAIN_CYCLES  = 12;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LINES  = 40;

    localparam logic [1:0] PHASE_FMT [NUM_PHASES] = '{
        FMT_RGB565, FMT_PACKED24, FMT_XRGB32, FMT_XRGB32_ALT,
        FMT_XRGB32_ALT, FMT_XRGB32, FMT_PACKED24, FMT_RGB565
    };

    // Parse position of the in-bench decoder
    typedef enum logic [2:0] {
        ST_HEADER, ST_SKIP, ST_PIXEL, ST_PAD, ST_DONE, ST_FAULT
    } t_parse_st;

    typedef struct {
        logic [7:0] value;
        logic       opens_file;
    } t_file_byte;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic [1:0] cfg_wdata;

    bmp24_in_if  byte_if ();
    bmp24_out_if pix_if ();

    bmp24_stream_to_framebuffer_pixels_top #(
        .MAX_DIM (IMG_MAX)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_byte      (byte_if.sink),
        .o_pix       (pix_if.source)
    );

    always #1 clk = ~clk;

    // Bytes waiting to be sent, and decoder results waiting to arrive
    t_file_byte pending_bytes [$];
    t_res       awaited_results [$];

    // Pacing, in percent of cycles
    int unsigned src_idle_pct;
    int unsigned sink_stall_pct;

    // Bookkeeping
    bit took_byte;
    int bytes_pushed;
    int bytes_taken;
    int files_sent;
    int results_seen;
    int pixels_seen;
    int verdicts_seen;
    int error_count;
    int quiet_cycles;

    // In-bench decoder state
    logic [1:0]  fmt_now;
    logic [31:0] pos_count;
    t_parse_st   parse_st;
    logic [31:0] width_q;
    logic [31:0] height_q;
    logic [15:0] depth_q;
    logic [31:0] offset_q;
    logic [1:0]  tri_pos;
    logic [15:0] bg_hold;
    logic [12:0] col_q;
    logic [12:0] row_q;
    logic [1:0]  pad_q;

    // ------------------------------------------------------------------------
    // Decoder
    // ------------------------------------------------------------------------

    // Back to the start of a header; the format register is left alone.
    function automatic void clear_parse();
        pos_count = '0;
        parse_st  = ST_HEADER;
        width_q   = '0;
        height_q  = '0;
        depth_q   = '0;
        offset_q  = '0;
        tri_pos   = '0;
        bg_hold   = '0;
        col_q     = '0;
        row_q     = '0;
        pad_q     = '0;
    endfunction

    // One byte of pixel data: gather blue and green, emit on red.
    function automatic bit take_pixel_byte(input logic [7:0] b, output t_res r);
        logic [31:0] top_row;
        r = '0;
        if (tri_pos == 2'd0) begin
            bg_hold = {8'h00, b};
            tri_pos = 2'd1;
            return 1'b0;
        end
        if (tri_pos == 2'd1) begin
            bg_hold[15:8] = b;
            tri_pos = 2'd2;
            return 1'b0;
        end
        tri_pos = 2'd0;
        // rows are stored bottom-up, so flip against the height
        top_row  = height_q - 32'd1 - 32'(row_q);
        r.kind   = KIND_PIXEL;
        r.row    = top_row[11:0];
        r.column = col_q[11:0];
        if (fmt_now == FMT_RGB565) begin
            r.pixel = {8'h00, b[7:3], bg_hold[15:10], bg_hold[7:3]};
        end else begin
            r.pixel = {b, bg_hold[15:8], bg_hold[7:0]};
        end
        col_q++;
        if (32'(col_q) >= width_q) begin
            col_q = '0;
            row_q++;
            if (32'(row_q) >= height_q) begin
                r.last   = 1'b1;
                parse_st = ST_DONE;
                return 1'b1;
            end
            pad_q = width_q[1:0];
            if (pad_q != 2'd0) begin
                parse_st = ST_PAD;
            end
        end
        return 1'b1;
    endfunction

    // Advance the decoder by one file byte; returns 1 when a result follows.
    function automatic bit decode_byte(input logic [7:0] b, input logic restart,
                                       output t_res r);
        logic [31:0] pos;
        bit          emit;
        r    = '0;
        emit = 1'b0;
        if (restart) begin
            clear_parse();
        end
        pos = pos_count;
        if (pos_count != 32'hFFFF_FFFF) begin
            pos_count++;
        end
        case (parse_st)
            ST_HEADER: begin
                if (pos == 0) begin
                    bg_hold = {8'h00, b};
                end else if (pos == 1) begin
                    if (bg_hold != {8'h00, SIG_B} || b != SIG_M) begin
                        r.kind   = KIND_BAD_SIG;
                        emit     = 1'b1;
                        parse_st = ST_FAULT;
                    end
                end else if (pos >= POS_OFFSET && pos <= POS_OFFSET + 3) begin
                    offset_q |= 32'(b) << (8 * (pos - POS_OFFSET));
                end else if (pos >= POS_WIDTH && pos <= POS_WIDTH + 3) begin
                    width_q |= 32'(b) << (8 * (pos - POS_WIDTH));
                end else if (pos >= POS_HEIGHT && pos <= POS_HEIGHT + 3) begin
                    height_q |= 32'(b) << (8 * (pos - POS_HEIGHT));
                end else if (pos == POS_DEPTH) begin
                    depth_q = {8'h00, b};
                end else if (pos == POS_DEPTH + 1) begin
                    depth_q[15:8] = b;
                    emit = 1'b1;
                    // depth is judged before size and offset
                    if (depth_q != DEPTH_RGB) begin
                        r.kind   = KIND_BAD_BPP;
                        parse_st = ST_FAULT;
                    end else if (width_q > IMG_MAX || height_q > IMG_MAX
                                 || offset_q < MIN_OFFSET) begin
                        r.kind   = KIND_BAD_SIZE;
                        parse_st = ST_FAULT;
                    end else begin
                        r.kind         = KIND_HDR_OK;
                        r.image_width  = width_q[12:0];
                        r.image_height = height_q[12:0];
                        parse_st = (width_q == 0 || height_q == 0) ? ST_DONE : ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                if (pos >= offset_q) begin
                    parse_st = ST_PIXEL;
                    emit     = take_pixel_byte(b, r);
                end
            end
            ST_PIXEL: begin
                emit = take_pixel_byte(b, r);
            end
            ST_PAD: begin
                pad_q = pad_q - 2'd1;
                if (pad_q == 2'd0) begin
                    parse_st = ST_PIXEL;
                end
            end
            default: begin
            end
        endcase
        return emit;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    // Print is capped so a badly broken block cannot flood the log.
    task automatic report_error(input string msg);
        if (error_count < REPORT_LINES) begin
            $display("[%0t] error: %s", $time, msg);
        end
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            report_error($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
                                   results_seen, name, want, got));
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus building
    // ------------------------------------------------------------------------

    task automatic push_byte(input logic [7:0] value, input logic opens_file);
        t_file_byte fb;
        fb.value      = value;
        fb.opens_file = opens_file;
        pending_bytes.push_back(fb);
        bytes_pushed++;
    endtask

    // Random bytes; start_pct of them open a new file.
    task automatic push_noise(input int n, input int unsigned start_pct);
        repeat (n) push_byte(8'($urandom), $urandom_range(99) < start_pct);
    endtask

    // The first cut bytes of a header with random filler between the fields.
    task automatic push_header(input logic [7:0] s0, input logic [7:0] s1,
                               input logic [31:0] off, input logic [31:0] w,
                               input logic [31:0] h, input logic [15:0] depth,
                               input int cut);
        logic [7:0] hdr [HDR_BYTES];
        foreach (hdr[k]) hdr[k] = 8'($urandom);
        hdr[0] = s0;
        hdr[1] = s1;
        for (int k = 0; k < 4; k++) begin
            hdr[POS_OFFSET + k] = off[8*k +: 8];
            hdr[POS_WIDTH + k]  = w[8*k +: 8];
            hdr[POS_HEIGHT + k] = h[8*k +: 8];
        end
        hdr[POS_DEPTH]     = depth[7:0];
        hdr[POS_DEPTH + 1] = depth[15:8];
        for (int k = 0; k < cut; k++) push_byte(hdr[k], k == 0);
        files_sent++;
    endtask

    // Gap up to the data offset, then up to max_pix pixels with row padding.
    task automatic push_image(input int unsigned off, input int unsigned w,
                              input int unsigned h, input int unsigned max_pix);
        int unsigned npix;
        for (int unsigned k = HDR_BYTES; k < off; k++) push_byte(8'($urandom), 1'b0);
        npix = (w * h < max_pix) ? w * h : max_pix;
        for (int unsigned p = 0; p < npix; p++) begin
            push_noise(3, 0);
            if ((p % w) == w - 1 && p != w * h - 1) begin
                push_noise(w & 3, 0);
            end
        end
    endtask

    // Mostly well-formed small images; the rest broken or plain noise.
    task automatic push_random_file();
        int unsigned pick;
        int unsigned w;
        int unsigned h;
        int unsigned off;
        int unsigned max_pix;
        logic [31:0] w_field;
        logic [31:0] h_field;
        logic [31:0] off_field;
        logic [15:0] depth;
        logic [7:0]  s0;
        logic [7:0]  s1;
        pick      = $urandom_range(99);
        w         = $urandom_range(1, 7);
        h         = $urandom_range(1, 4);
        off       = 54 + $urandom_range(0, 5);
        max_pix   = w * h;
        depth     = DEPTH_RGB;
        s0        = SIG_B;
        s1        = SIG_M;
        if (pick < 8) begin
            if ($urandom_range(1)) w = 0; else h = 0;
        end else if (pick >= 70 && pick < 76) begin
            if ($urandom_range(1)) s0 = SIG_B ^ 8'($urandom_range(1, 255));
            else                   s1 = SIG_M ^ 8'($urandom_range(1, 255));
        end else if (pick >= 76 && pick < 82) begin
            depth = DEPTH_RGB ^ 16'($urandom_range(1, 65535));
        end else if (pick >= 93 && pick < 97) begin
            max_pix = $urandom_range(0, w * h - 1);
        end else if (pick >= 97) begin
            // noise with the odd restart among it
            push_noise($urandom_range(3, 12), 15);
            return;
        end
        w_field   = w;
        h_field   = h;
        off_field = off;
        if (pick >= 82 && pick < 88) begin
            if ($urandom_range(1)) w_field = IMG_MAX + 1 + $urandom_range(0, 65535);
            else                   h_field = $urandom | 32'h8000_0000;
        end else if (pick >= 88 && pick < 93) begin
            off_field = $urandom_range(0, 53);
        end
        push_header(s0, s1, off_field, w_field, h_field, depth, HDR_BYTES);
        if (pick < 70 || pick >= 93) begin
            push_image(off, w, h, max_pix);
        end
        // trailing bytes, ignored by a finished or failed parse
        push_noise($urandom_range(0, 4), 0);
    endtask

    // Write the format only once the block has gone quiet.
    task automatic write_format(input logic [1:0] fmt);
        while (pending_bytes.size() != 0 || awaited_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = fmt;
        @(negedge clk);
        cfg_we  = 1'b0;
        fmt_now = fmt;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Byte channel: accept at the rising edge, drive at the falling edge
    // ------------------------------------------------------------------------

    // An accepted byte leaves the queue and runs through the decoder at once;
    // any result it causes joins the back of the awaited queue.
    always @(posedge clk) begin : byte_accept
        t_file_byte fb;
        t_res       r;
        took_byte = rst_n && byte_if.valid && byte_if.ready;
        if (took_byte) begin
            fb = pending_bytes.pop_front();
            bytes_taken++;
            if (decode_byte(fb.value, fb.opens_file, r)) begin
                awaited_results.push_back(r);
            end
        end
    end

    // Hold an offered byte until it is taken; otherwise offer the next one
    // unless this cycle is picked as idle. Ready on the result side is
    // re-rolled every cycle.
    always @(negedge clk) begin : channel_drive
        if (!rst_n) begin
            byte_if.valid <= 1'b0;
        end else if (byte_if.valid && !took_byte) begin
            // hold
        end else if (pending_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
            byte_if.valid     <= 1'b1;
            byte_if.byte_in   <= pending_bytes[0].value;
            byte_if.start_req <= pending_bytes[0].opens_file;
        end else begin
            byte_if.valid <= 1'b0;
        end
        pix_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Result channel: compare each result with the oldest awaited one
    // ------------------------------------------------------------------------
    always @(posedge clk) begin : result_monitor
        t_res want;
        if (rst_n && pix_if.valid && pix_if.ready) begin
            results_seen++;
            if (awaited_results.size() == 0) begin
                report_error($sformatf("result %0d (kind %0d) arrived with nothing awaited",
                                       results_seen, pix_if.kind));
            end else begin
                want = awaited_results.pop_front();
                check_field("kind",         want.kind,         pix_if.kind);
                check_field("row",          want.row,          pix_if.row);
                check_field("column",       want.column,       pix_if.column);
                check_field("pixel",        want.pixel,        pix_if.pixel);
                check_field("image_width",  want.image_width,  pix_if.image_width);
                check_field("image_height", want.image_height, pix_if.image_height);
                check_field("last",         want.last,         pix_if.last);
                if (want.kind == KIND_PIXEL) pixels_seen++;
                else                         verdicts_seen++;
            end
        end
    end

    // Watchdog: give up once neither channel has moved for too long.
    always @(posedge clk) begin : progress_watch
        if ((byte_if.valid && byte_if.ready) || (pix_if.valid && pix_if.ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles, %0d bytes queued, %0d awaited",
                     quiet_cycles, pending_bytes.size(), awaited_results.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_wdata         = FMT_RGB565;
        byte_if.valid     = 1'b0;
        byte_if.byte_in   = 8'h00;
        byte_if.start_req = 1'b0;
        pix_if.ready      = 1'b0;
        src_idle_pct      = 0;
        sink_stall_pct    = 0;
        fmt_now           = FMT_RGB565;
        clear_parse();

        // Synchronous reset, released away from the sampling edge
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_format(PHASE_FMT[p]);
            // Pacing cycles through: none, idle sender, stalling receiver, both a little
            case (p % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 81; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 81; end
                default: begin src_idle_pct = 20; sink_stall_pct = 20; end
            endcase

            if (p == 0) begin
                // Small image with row padding, trailing bytes after the last pixel
                push_header(SIG_B, SIG_M, 54, 3, 2, DEPTH_RGB, HDR_BYTES);
                push_image(54, 3, 2, 6);
                push_noise(3, 0);
                // Bad signature, first byte then second byte
                push_header(8'h41, SIG_M, 54, 1, 1, DEPTH_RGB, HDR_BYTES);
                push_header(SIG_B, 8'h4E, 54, 1, 1, DEPTH_RGB, HDR_BYTES);
                push_noise(4, 0);
                // Bad depth wins over an oversize width; depth with a high byte
                push_header(SIG_B, SIG_M, 54, 5000, 1, 16'd32, HDR_BYTES);
                push_header(SIG_B, SIG_M, 54, 1, 1, 16'h0118, HDR_BYTES);
                // Size and offset limits
                push_header(SIG_B, SIG_M, 54, IMG_MAX + 1, 1, DEPTH_RGB, HDR_BYTES);
                push_header(SIG_B, SIG_M, 54, 1, 32'hFFFF_FFFF, DEPTH_RGB, HDR_BYTES);
                push_header(SIG_B, SIG_M, 53, 1, 1, DEPTH_RGB, HDR_BYTES);
                // Empty image: accepted, then everything after is dropped
                push_header(SIG_B, SIG_M, 54, 0, 5, DEPTH_RGB, HDR_BYTES);
                push_noise(5, 0);
                // Largest image: a few pixels, then restart mid-triplet
                push_header(SIG_B, SIG_M, 54, IMG_MAX, IMG_MAX, DEPTH_RGB, HDR_BYTES);
                push_image(54, IMG_MAX, IMG_MAX, 4);
                push_noise(2, 0);
                // Restart part-way through a header
                push_header(SIG_B, SIG_M, 54, 2, 2, DEPTH_RGB, 14);
                // Huge data offset: parse stays in the gap until the restart
                push_header(SIG_B, SIG_M, 32'hFFFF_FFFF, 1, 1, DEPTH_RGB, HDR_BYTES);
                push_noise(6, 0);
                // Offset past the minimum, four pixels wide, no padding
                push_header(SIG_B, SIG_M, 60, 4, 2, DEPTH_RGB, HDR_BYTES);
                push_image(60, 4, 2, 8);
            end

            // Random files until this phase has its share of bytes
            begin
                int phase_start;
                phase_start = bytes_pushed;
                while (bytes_pushed - phase_start < PHASE_BYTES) push_random_file();
            end
        end

        // Drain, then give the pipeline time to show anything unexpected
        while (pending_bytes.size() != 0 || awaited_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run: %0d file bytes in %0d files, all four format settings, four pacings",
                 bytes_taken, files_sent);
        $display("run: %0d results checked (%0d pixels, %0d verdicts), %0d errors",
                 results_seen, pixels_seen, verdicts_seen, error_count);
        if (error_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/bmp24_pkg.sv
sv/bmp24_in_if.sv
sv/bmp24_out_if.sv
sv/bmp24_queue.sv
sv/bmp24_front.sv
sv/bmp24_back.sv
sv/bmp24_stream_to_framebuffer_pixels_top.sv
sv/bmp24_chk.sv
tb/tb_top.sv
